// ===== rtl/mpjs_pkg.sv =====
// Shared types, constants and codes for the multi-policy job schedule evaluator.
// Used by mpjs_ctrl, mpjs_datapath and the top level; depends on nothing.
package mpjs_pkg;

   localparam int MAX_JOBS = 32;
   localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);
   localparam int TIME_W   = 22;
   localparam int STAMP_W  = 24;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_RUN   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [2:0] POL_FCFS = 3'd0;
   localparam logic [2:0] POL_SJF  = 3'd1;
   localparam logic [2:0] POL_PRI  = 3'd2;
   localparam logic [2:0] POL_RR   = 3'd3;
   localparam logic [2:0] POL_SRTF = 3'd4;
   localparam logic [2:0] POL_HRRN = 3'd5;

   localparam logic [1:0] CSR_POLICY  = 2'd0;
   localparam logic [1:0] CSR_QUANTUM = 2'd1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_RUN_INIT,
      OP_RI_RD,
      OP_RI_LAT,
      OP_RK_RD,
      OP_RK_CMP,
      OP_R_WR,
      OP_SC_INIT,
      OP_S_ORD,
      OP_S_TBL,
      OP_S_MUL,
      OP_S_EVAL,
      OP_S_DEC
   } op_type;

   typedef struct packed {
      logic count_zero;
      logic last_k;
      logic last_i;
      logic last_pos;
      logic dec_end;
      logic is_hrrn;
   } status_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [15:0] arr;
      logic [15:0] bur;
      logic [7:0]  pri;
   } job_type;

   typedef struct packed {
      logic [15:0]        rem;
      logic               done;
      logic               queued;
      logic [STAMP_W-1:0] stamp;
   } prog_type;

endpackage

// ===== rtl/mpjs_ctrl.sv =====
// Sequencer for the schedule evaluator: decodes start words and steps the
// datapath through ranking, scans and decisions. Depends on mpjs_pkg.
module mpjs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_kind,
   input  mpjs_pkg::status_type   status,
   output logic                   busy,
   output mpjs_pkg::op_type       op
);
   import mpjs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RI_RD,
      ST_RI_LAT,
      ST_RK_RD,
      ST_RK_CMP,
      ST_R_WR,
      ST_SC_INIT,
      ST_S_ORD,
      ST_S_TBL,
      ST_S_MUL,
      ST_S_EVAL,
      ST_S_DEC
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  KIND_LOAD:  op = OP_LOAD;
                  KIND_CLEAR: op = OP_CLEAR;
                  KIND_RUN: begin
                     if (!status.count_zero) begin
                        op       = OP_RUN_INIT;
                        state_in = ST_RI_RD;
                     end
                  end
                  default: op = OP_NONE;
               endcase
            end
         end
         ST_RI_RD: begin
            op       = OP_RI_RD;
            state_in = ST_RI_LAT;
         end
         ST_RI_LAT: begin
            op       = OP_RI_LAT;
            state_in = ST_RK_RD;
         end
         ST_RK_RD: begin
            op       = OP_RK_RD;
            state_in = ST_RK_CMP;
         end
         ST_RK_CMP: begin
            op       = OP_RK_CMP;
            state_in = status.last_k ? ST_R_WR : ST_RK_RD;
         end
         ST_R_WR: begin
            op       = OP_R_WR;
            state_in = status.last_i ? ST_SC_INIT : ST_RI_RD;
         end
         ST_SC_INIT: begin
            op       = OP_SC_INIT;
            state_in = ST_S_ORD;
         end
         ST_S_ORD: begin
            op       = OP_S_ORD;
            state_in = ST_S_TBL;
         end
         ST_S_TBL: begin
            op       = OP_S_TBL;
            state_in = status.is_hrrn ? ST_S_MUL : ST_S_EVAL;
         end
         ST_S_MUL: begin
            op       = OP_S_MUL;
            state_in = ST_S_EVAL;
         end
         ST_S_EVAL: begin
            op       = OP_S_EVAL;
            state_in = status.last_pos ? ST_S_DEC : ST_S_ORD;
         end
         ST_S_DEC: begin
            op       = OP_S_DEC;
            state_in = status.dec_end ? ST_IDLE : ST_SC_INIT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/mpjs_datapath.sv =====
// Job table, progress and order memories, ranking and scan logic, decision
// arithmetic and the result word register. Depends on mpjs_pkg.
module mpjs_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  mpjs_pkg::op_type          op,
   input  logic [7:0]                req_process_tag,
   input  logic [15:0]               req_arrival_time,
   input  logic [15:0]               req_burst_time,
   input  logic [7:0]                req_priority_level,
   input  logic [2:0]                policy,
   input  logic [15:0]               quantum,
   output mpjs_pkg::status_type      status,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_job_tag,
   output logic [15:0]               rsp_job_arrival,
   output logic [15:0]               rsp_job_burst,
   output logic [7:0]                rsp_job_priority,
   output logic [mpjs_pkg::TIME_W-1:0] rsp_completion_time,
   output logic [mpjs_pkg::TIME_W-1:0] rsp_turnaround_time,
   output logic [mpjs_pkg::TIME_W-1:0] rsp_waiting_time,
   output logic                      rsp_is_last,
   output logic                      rsp_table_overflowed
);
   import mpjs_pkg::*;

   localparam int KEY_W  = 32 + STAMP_W;
   localparam int PROD_W = TIME_W + 1 + 16;

   job_type            table_mem [MAX_JOBS];
   prog_type           prog_mem  [MAX_JOBS];
   logic [IDX_W-1:0]   order_mem [MAX_JOBS];

   logic [CNT_W-1:0]   job_count_ff;
   logic               ovf_ff;
   logic [IDX_W-1:0]   i_ff, k_ff, pos_ff, rank_ff;
   logic [15:0]        arr_i_ff;
   job_type            tbl_rd_ff;
   prog_type           prog_rd_ff;
   logic [IDX_W-1:0]   ord_rd_ff;
   logic [TIME_W-1:0]  sim_clock_ff;
   logic [STAMP_W-1:0] cnt_ff;
   logic [CNT_W-1:0]   done_ff;
   logic               have_ff, later_ff;
   logic [15:0]        next_arr_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   job_type            best_job_ff;
   logic [15:0]        best_rem_ff;
   logic [KEY_W-1:0]   best_key_ff;
   logic [PROD_W-1:0]  lhs_ff, rhs_ff;
   logic               rsp_valid_ff, rsp_last_ff, rsp_ovf_ff;
   job_type            rsp_job_ff;
   logic [TIME_W-1:0]  rsp_ct_ff, rsp_tat_ff, rsp_wt_ff;

   logic               pol_rr, pol_srtf, pol_hrrn, queue_mode;
   logic               arrived, in_ready, admit, better;
   logic [STAMP_W-1:0] eff_stamp;
   logic [15:0]        key16;
   logic [KEY_W-1:0]   cand_key;
   logic [15:0]        q_eff, slice, new_rem;
   logic [TIME_W-1:0]  new_clock, tat, wt;
   logic               fin, reinsert;
   logic [STAMP_W-1:0] reins_stamp, cnt_next;
   logic [CNT_W-1:0]   done_inc;
   logic [TIME_W:0]    wait_c, wait_b;

   assign pol_rr     = (policy == POL_RR);
   assign pol_srtf   = (policy == POL_SRTF);
   assign pol_hrrn   = (policy == POL_HRRN);
   assign queue_mode = pol_rr || pol_srtf;

   // Scan element evaluation
   assign arrived  = (TIME_W'(tbl_rd_ff.arr) <= sim_clock_ff);
   assign in_ready = !prog_rd_ff.done && (arrived || (queue_mode && prog_rd_ff.queued));
   assign admit    = queue_mode && !prog_rd_ff.done && !prog_rd_ff.queued && arrived;
   assign eff_stamp = admit ? cnt_ff : prog_rd_ff.stamp;

   always_comb begin
      case (policy)
         POL_SJF:  key16 = tbl_rd_ff.bur;
         POL_PRI:  key16 = {8'd0, tbl_rd_ff.pri};
         POL_SRTF: key16 = prog_rd_ff.rem;
         default:  key16 = 16'd0;
      endcase
   end

   assign cand_key = pol_rr ? {eff_stamp, tbl_rd_ff.arr, 16'd0}
                            : {key16, tbl_rd_ff.arr, eff_stamp};
   assign better   = !have_ff || (pol_hrrn ? (lhs_ff > rhs_ff) : (cand_key < best_key_ff));

   // HRRN ratio terms: wait plus burst for the element and for the best so far
   assign wait_c = (TIME_W + 1)'(sim_clock_ff) - (TIME_W + 1)'(tbl_rd_ff.arr)
                 + (TIME_W + 1)'(tbl_rd_ff.bur);
   assign wait_b = (TIME_W + 1)'(sim_clock_ff) - (TIME_W + 1)'(best_job_ff.arr)
                 + (TIME_W + 1)'(best_job_ff.bur);

   // Decision after a full scan
   assign q_eff    = (quantum == 16'd0) ? 16'd1 : quantum;
   assign slice    = (best_rem_ff < q_eff) ? best_rem_ff : q_eff;
   assign done_inc = done_ff + CNT_W'(1);

   always_comb begin
      new_clock   = sim_clock_ff;
      new_rem     = best_rem_ff;
      fin         = 1'b0;
      reinsert    = 1'b0;
      reins_stamp = cnt_ff;
      cnt_next    = cnt_ff;
      if (pol_srtf) begin
         cnt_next    = cnt_ff + STAMP_W'(2);
         reins_stamp = cnt_ff + STAMP_W'(1);
         if (best_rem_ff == 16'd0) begin
            fin = 1'b1;
         end else begin
            new_rem   = best_rem_ff - 16'd1;
            new_clock = sim_clock_ff + TIME_W'(1);
            fin       = (new_rem == 16'd0);
            reinsert  = !fin;
         end
      end else if (pol_rr) begin
         cnt_next    = cnt_ff + STAMP_W'(1);
         reins_stamp = cnt_ff + STAMP_W'(2);
         new_rem     = best_rem_ff - slice;
         new_clock   = sim_clock_ff + TIME_W'(slice);
         fin         = (new_rem == 16'd0);
         reinsert    = !fin;
      end else begin
         new_clock = sim_clock_ff + TIME_W'(best_job_ff.bur);
         fin       = 1'b1;
      end
   end

   assign tat = new_clock - TIME_W'(best_job_ff.arr);
   assign wt  = tat - TIME_W'(best_job_ff.bur);

   assign status.count_zero = (job_count_ff == '0);
   assign status.last_k     = ((CNT_W'(k_ff) + CNT_W'(1)) == job_count_ff);
   assign status.last_i     = ((CNT_W'(i_ff) + CNT_W'(1)) == job_count_ff);
   assign status.last_pos   = ((CNT_W'(pos_ff) + CNT_W'(1)) == job_count_ff);
   assign status.dec_end    = have_ff ? (fin && (done_inc == job_count_ff)) : !later_ff;
   assign status.is_hrrn    = pol_hrrn;

   // Memories
   always_ff @(posedge clock) begin
      if (op == OP_LOAD && job_count_ff < CNT_W'(MAX_JOBS)) begin
         table_mem[job_count_ff[IDX_W-1:0]] <= '{tag: req_process_tag,
                                                 arr: req_arrival_time,
                                                 bur: req_burst_time,
                                                 pri: req_priority_level};
      end
      if (op == OP_RI_RD) begin
         tbl_rd_ff <= table_mem[i_ff];
      end else if (op == OP_RK_RD) begin
         tbl_rd_ff <= table_mem[k_ff];
      end else if (op == OP_S_TBL) begin
         tbl_rd_ff <= table_mem[ord_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_R_WR) begin
         order_mem[rank_ff] <= i_ff;
      end
      if (op == OP_S_ORD) begin
         ord_rd_ff <= order_mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (op == OP_RI_LAT) begin
         prog_mem[i_ff] <= '{rem: tbl_rd_ff.bur, done: 1'b0, queued: 1'b0, stamp: '0};
      end else if (op == OP_S_EVAL && admit) begin
         prog_mem[ord_rd_ff] <= '{rem: prog_rd_ff.rem, done: 1'b0, queued: 1'b1,
                                  stamp: cnt_ff};
      end else if (op == OP_S_DEC && have_ff && fin) begin
         prog_mem[best_idx_ff] <= '{rem: 16'd0, done: 1'b1, queued: 1'b0, stamp: '0};
      end else if (op == OP_S_DEC && have_ff && reinsert) begin
         prog_mem[best_idx_ff] <= '{rem: new_rem, done: 1'b0, queued: 1'b1,
                                    stamp: reins_stamp};
      end
      if (op == OP_S_TBL) begin
         prog_rd_ff <= prog_mem[ord_rd_ff];
      end
   end

   // Table bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff <= '0;
         ovf_ff       <= 1'b0;
      end else if (op == OP_CLEAR) begin
         job_count_ff <= '0;
         ovf_ff       <= 1'b0;
      end else if (op == OP_LOAD) begin
         if (job_count_ff < CNT_W'(MAX_JOBS)) begin
            job_count_ff <= job_count_ff + CNT_W'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   // Ranking, scan and simulation state
   always_ff @(posedge clock) begin
      case (op)
         OP_RUN_INIT: begin
            i_ff         <= '0;
            sim_clock_ff <= '0;
            cnt_ff       <= '0;
            done_ff      <= '0;
         end
         OP_RI_LAT: begin
            arr_i_ff <= tbl_rd_ff.arr;
            k_ff     <= '0;
            rank_ff  <= '0;
         end
         OP_RK_CMP: begin
            if (tbl_rd_ff.arr < arr_i_ff || (tbl_rd_ff.arr == arr_i_ff && k_ff < i_ff)) begin
               rank_ff <= rank_ff + IDX_W'(1);
            end
            k_ff <= k_ff + IDX_W'(1);
         end
         OP_R_WR: begin
            i_ff <= i_ff + IDX_W'(1);
         end
         OP_SC_INIT: begin
            pos_ff   <= '0;
            have_ff  <= 1'b0;
            later_ff <= 1'b0;
         end
         OP_S_MUL: begin
            lhs_ff <= wait_c * best_job_ff.bur;
            rhs_ff <= wait_b * tbl_rd_ff.bur;
         end
         OP_S_EVAL: begin
            pos_ff <= pos_ff + IDX_W'(1);
            if (in_ready) begin
               if (better) begin
                  have_ff     <= 1'b1;
                  best_idx_ff <= ord_rd_ff;
                  best_job_ff <= tbl_rd_ff;
                  best_rem_ff <= prog_rd_ff.rem;
                  best_key_ff <= cand_key;
               end
            end else if (!prog_rd_ff.done) begin
               if (!later_ff || tbl_rd_ff.arr < next_arr_ff) begin
                  later_ff    <= 1'b1;
                  next_arr_ff <= tbl_rd_ff.arr;
               end
            end
         end
         OP_S_DEC: begin
            if (have_ff) begin
               sim_clock_ff <= new_clock;
               cnt_ff       <= cnt_next;
               if (fin) begin
                  done_ff <= done_inc;
               end
            end else if (later_ff) begin
               sim_clock_ff <= TIME_W'(next_arr_ff);
            end
         end
         default: ;
      endcase
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (op == OP_S_DEC) && have_ff && fin;
      end
      if (op == OP_S_DEC) begin
         rsp_job_ff  <= best_job_ff;
         rsp_ct_ff   <= new_clock;
         rsp_tat_ff  <= tat;
         rsp_wt_ff   <= wt;
         rsp_last_ff <= (done_inc == job_count_ff);
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_job_tag          = rsp_job_ff.tag;
   assign rsp_job_arrival      = rsp_job_ff.arr;
   assign rsp_job_burst        = rsp_job_ff.bur;
   assign rsp_job_priority     = rsp_job_ff.pri;
   assign rsp_completion_time  = rsp_ct_ff;
   assign rsp_turnaround_time  = rsp_tat_ff;
   assign rsp_waiting_time     = rsp_wt_ff;
   assign rsp_is_last          = rsp_last_ff;
   assign rsp_table_overflowed = rsp_ovf_ff;

   a_dec_below_count: assert property (@(posedge clock) disable iff (reset)
      (op == OP_S_DEC) |-> (done_ff < job_count_ff))
      else $error("decision taken with every job already finished");

   a_last_all_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (done_ff == job_count_ff))
      else $error("last word flagged before every job finished");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result words closer than one scan apart");

   a_full_load_flags: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LOAD && job_count_ff == CNT_W'(MAX_JOBS)) |=> ovf_ff)
      else $error("dropped load did not raise overflow");

endmodule

// ===== rtl/multi_policy_job_schedule_evaluator.sv =====
// Top level of the multi-policy job schedule evaluator: configuration
// registers, sequencer and datapath. Depends on mpjs_pkg, mpjs_ctrl, mpjs_datapath.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+------------------------------------
//   request  | start, busy, req_*            | word taken when start && !busy
//   result   | rsp_valid, rsp_*              | one-cycle strobe, no back-pressure
//   config   | csr_we, csr_index, csr_wdata  | written on every edge with csr_we
//
// Load and clear words keep busy low, and the next word may follow at once.
// A run word first ranks the jobs by arrival, then makes decisions, each one
// scan of the job table (order read, table read and evaluation for each job,
// with a cross-product step under HRRN) between a scan set-up and a decision step.
// Decisions: one per job for FCFS, SJF, priority and HRRN, one per time
// slice for round robin, one per tick for SRTF, plus one per idle jump.
// Reset is synchronous and empties the table; the result side cannot stall.
module multi_policy_job_schedule_evaluator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [7:0]                  req_process_tag,
   input  logic [15:0]                 req_arrival_time,
   input  logic [15:0]                 req_burst_time,
   input  logic [7:0]                  req_priority_level,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_wdata,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_job_tag,
   output logic [15:0]                 rsp_job_arrival,
   output logic [15:0]                 rsp_job_burst,
   output logic [7:0]                  rsp_job_priority,
   output logic [mpjs_pkg::TIME_W-1:0] rsp_completion_time,
   output logic [mpjs_pkg::TIME_W-1:0] rsp_turnaround_time,
   output logic [mpjs_pkg::TIME_W-1:0] rsp_waiting_time,
   output logic                        rsp_is_last,
   output logic                        rsp_table_overflowed
);
   import mpjs_pkg::*;

   logic [2:0]  policy_ff;
   logic [15:0] quantum_ff;
   op_type      op;
   status_type  status;

   // Configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= POL_FCFS;
         quantum_ff <= 16'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:  policy_ff  <= csr_wdata[2:0];
            CSR_QUANTUM: quantum_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: decode the request word, step ranking, scans and decisions
   mpjs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .busy     (busy),
      .op       (op)
   );

   // Storage and arithmetic; drives the result word
   mpjs_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .op                   (op),
      .req_process_tag      (req_process_tag),
      .req_arrival_time     (req_arrival_time),
      .req_burst_time       (req_burst_time),
      .req_priority_level   (req_priority_level),
      .policy               (policy_ff),
      .quantum              (quantum_ff),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_job_tag          (rsp_job_tag),
      .rsp_job_arrival      (rsp_job_arrival),
      .rsp_job_burst        (rsp_job_burst),
      .rsp_job_priority     (rsp_job_priority),
      .rsp_completion_time  (rsp_completion_time),
      .rsp_turnaround_time  (rsp_turnaround_time),
      .rsp_waiting_time     (rsp_waiting_time),
      .rsp_is_last          (rsp_is_last),
      .rsp_table_overflowed (rsp_table_overflowed)
   );

endmodule

// ===== tb/mpjs_sched_scoreboard.sv =====
// Scoreboard for the multi-policy job schedule evaluator: keeps its own job
// table, replays each run word under the active policy and checks completions.
// Depends on nothing; the top level of the testbench includes it in its build.

typedef struct {
   bit [7:0]  tag;
   bit [15:0] arr;
   bit [15:0] bur;
   bit [7:0]  pri;
   bit [21:0] comp;
   bit [21:0] tat;
   bit [21:0] wt;
   bit        last;
   bit        ovf;
} completion_rec;

class sched_scoreboard;
   bit [7:0]    tag[32];
   bit [15:0]   arr[32];
   bit [15:0]   bur[32];
   bit [7:0]    pri[32];
   int unsigned rem[32];
   bit          done[32];
   int          order[32];
   int          ready[$];
   int          job_cnt;
   bit          ovf;
   bit [2:0]    pol;
   bit [15:0]   quant;
   int unsigned clk;
   completion_rec pending[$];
   int          errors;
   int          seen;

   function new();
      job_cnt = 0; ovf = 0; pol = 0; quant = 4; errors = 0; seen = 0;
   endfunction

   function void set_reg(bit [1:0] idx, bit [15:0] data);
      if (idx == 2'd0) pol = data[2:0];
      else if (idx == 2'd1) quant = data;
   endfunction

   function void complete(int j);
      completion_rec r;
      r.tag = tag[j]; r.arr = arr[j]; r.bur = bur[j]; r.pri = pri[j];
      r.comp = clk[21:0];
      r.tat = clk[21:0] - 22'(arr[j]);
      r.wt = r.tat - 22'(bur[j]);
      r.last = 0;
      r.ovf = ovf;
      done[j] = 1;
      rem[j] = 0;
      pending.push_back(r);
   endfunction

   // Mode 0 keys on burst, 1 on priority, 2 on remaining burst.
   function bit beats(int a, int b, int mode);
      int unsigned ka, kb;
      if (mode == 0) begin
         ka = bur[a]; kb = bur[b];
      end else if (mode == 1) begin
         ka = pri[a]; kb = pri[b];
      end else begin
         ka = rem[a]; kb = rem[b];
      end
      if (ka == kb) return arr[a] < arr[b];
      return ka < kb;
   endfunction

   function void insert_ranked(int j, int mode);
      int pos;
      pos = 0;
      while (pos < ready.size() && !beats(j, ready[pos], mode)) pos++;
      ready.insert(pos, j);
   endfunction

   function void run_nonpreempt(int n, int mode);
      int p, fin, j;
      p = 0; fin = 0;
      while (fin < n) begin
         while (p < n && arr[order[p]] <= clk) begin
            insert_ranked(order[p], mode);
            p++;
         end
         if (ready.size() > 0) begin
            j = ready.pop_front();
            clk += bur[j];
            complete(j);
            fin++;
         end else if (p < n) begin
            clk = arr[order[p]];
         end else break;
      end
   endfunction

   function void run_round_robin(int n);
      int p, fin, j;
      int unsigned q, slice;
      p = 0; fin = 0;
      q = (quant == 0) ? 1 : quant;
      if (n > 0 && arr[order[0]] > clk) clk = arr[order[0]];
      while (p < n && arr[order[p]] <= clk) begin ready.push_back(order[p]); p++; end
      while (ready.size() > 0) begin
         j = ready.pop_front();
         slice = (rem[j] < q) ? rem[j] : q;
         rem[j] -= slice;
         clk += slice;
         while (p < n && arr[order[p]] <= clk) begin ready.push_back(order[p]); p++; end
         if (rem[j] > 0) ready.push_back(j);
         else begin
            complete(j);
            fin++;
         end
         if (ready.size() == 0 && fin < n && p < n) begin
            if (clk < arr[order[p]]) clk = arr[order[p]];
            while (p < n && arr[order[p]] <= clk) begin ready.push_back(order[p]); p++; end
         end
      end
   endfunction

   function void run_srtf(int n);
      int p, fin, j;
      p = 0; fin = 0;
      if (n > 0) clk = arr[order[0]];
      while (fin < n) begin
         while (p < n && arr[order[p]] <= clk) begin
            insert_ranked(order[p], 2);
            p++;
         end
         if (ready.size() > 0) begin
            j = ready.pop_front();
            if (rem[j] == 0) begin
               complete(j);
               fin++;
            end else begin
               clk++;
               rem[j]--;
               if (rem[j] == 0) begin
                  complete(j);
                  fin++;
               end else insert_ranked(j, 2);
            end
         end else if (p < n) begin
            clk = arr[order[p]];
         end else break;
      end
   endfunction

   function void run_hrrn(int n);
      int fin, k, j, best;
      bit have, later;
      int unsigned next_arr;
      longint unsigned lhs, rhs;
      fin = 0;
      while (fin < n) begin
         have = 0; later = 0; best = 0; next_arr = 0;
         for (k = 0; k < n; k++) begin
            j = order[k];
            if (done[j]) continue;
            if (arr[j] <= clk) begin
               if (!have) begin
                  best = j; have = 1;
               end else begin
                  // compare (wait + burst) / burst exactly by cross products
                  lhs = longint'(clk - arr[j] + bur[j]) * bur[best];
                  rhs = longint'(clk - arr[best] + bur[best]) * bur[j];
                  if (lhs > rhs) best = j;
               end
            end else if (!later || arr[j] < next_arr) begin
               next_arr = arr[j];
               later = 1;
            end
         end
         if (have) begin
            clk += bur[best];
            complete(best);
            fin++;
         end else if (later) clk = next_arr;
         else break;
      end
   endfunction

   // Note one accepted input word and queue the completions it causes.
   function void note_word(bit [1:0] kind, bit [7:0] t, bit [15:0] a, bit [15:0] b,
                           bit [7:0] pr);
      int i, k, base;
      if (kind == 2'd0) begin
         if (job_cnt < 32) begin
            tag[job_cnt] = t; arr[job_cnt] = a; bur[job_cnt] = b; pri[job_cnt] = pr;
            job_cnt++;
         end else ovf = 1;
         return;
      end
      if (kind == 2'd2) begin
         job_cnt = 0; ovf = 0; ready.delete();
         return;
      end
      if (kind != 2'd1) return;
      // stable insertion sort by arrival
      for (i = 0; i < job_cnt; i++) begin
         k = i;
         while (k > 0 && arr[order[k-1]] > arr[i]) begin
            order[k] = order[k-1];
            k--;
         end
         order[k] = i;
         rem[i] = bur[i];
         done[i] = 0;
      end
      ready.delete();
      clk = 0;
      base = pending.size();
      case (pol)
         3'd1: run_nonpreempt(job_cnt, 0);
         3'd2: run_nonpreempt(job_cnt, 1);
         3'd3: run_round_robin(job_cnt);
         3'd4: run_srtf(job_cnt);
         3'd5: run_hrrn(job_cnt);
         default: begin
            for (k = 0; k < job_cnt; k++) begin
               i = order[k];
               if (clk < arr[i]) clk = arr[i];
               clk += bur[i];
               complete(i);
            end
         end
      endcase
      if (pending.size() > base) pending[pending.size()-1].last = 1;
   endfunction

   function void compare(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Check one completion word against the oldest expectation.
   function void check_word(completion_rec got);
      completion_rec want;
      seen++;
      if (pending.size() == 0) begin
         $error("unexpected completion word for tag %0d", got.tag);
         errors++;
         return;
      end
      want = pending.pop_front();
      compare("job_tag", want.tag, got.tag);
      compare("job_arrival", want.arr, got.arr);
      compare("job_burst", want.bur, got.bur);
      compare("job_priority", want.pri, got.pri);
      compare("completion_time", want.comp, got.comp);
      compare("turnaround_time", want.tat, got.tat);
      compare("waiting_time", want.wt, got.wt);
      compare("is_last", want.last, got.last);
      compare("table_overflowed", want.ovf, got.ovf);
   endfunction
endclass

// ===== tb/tb_multi_policy_job_schedule_evaluator.sv =====
// Testbench top for multi_policy_job_schedule_evaluator: directed and random
// job tables run under every policy. Depends on mpjs_pkg, the RTL and
// mpjs_sched_scoreboard.sv.
module tb_multi_policy_job_schedule_evaluator;
   import mpjs_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_kind = 0;
   logic [7:0]  req_process_tag = 0;
   logic [15:0] req_arrival_time = 0;
   logic [15:0] req_burst_time = 0;
   logic [7:0]  req_priority_level = 0;
   logic        csr_we = 0;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_wdata = 0;
   logic        rsp_valid;
   logic [7:0]  rsp_job_tag;
   logic [15:0] rsp_job_arrival;
   logic [15:0] rsp_job_burst;
   logic [7:0]  rsp_job_priority;
   logic [TIME_W-1:0] rsp_completion_time;
   logic [TIME_W-1:0] rsp_turnaround_time;
   logic [TIME_W-1:0] rsp_waiting_time;
   logic        rsp_is_last;
   logic        rsp_table_overflowed;

   sched_scoreboard sb = new();
   int  words_sent = 0;
   int  runs_sent = 0;
   int  cycles = 0;
   bit  calm = 0;   // suppress sender idling during the quiet stretch

   localparam int CYCLE_LIMIT = 4000000;

   multi_policy_job_schedule_evaluator dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Capture every completion word; the receiver never stalls.
   always @(posedge clock) begin
      completion_rec got;
      if (!reset && rsp_valid) begin
         got.tag = rsp_job_tag; got.arr = rsp_job_arrival; got.bur = rsp_job_burst;
         got.pri = rsp_job_priority; got.comp = rsp_completion_time;
         got.tat = rsp_turnaround_time; got.wt = rsp_waiting_time;
         got.last = rsp_is_last; got.ovf = rsp_table_overflowed;
         sb.check_word(got);
      end
   end

   // Drive one word; hold it until the block takes it.
   task automatic send_word(logic [1:0] kind, logic [7:0] t, logic [15:0] a,
                            logic [15:0] b, logic [7:0] pr);
      if (!calm && $urandom_range(99) < 10) begin
         start = 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      start = 1;
      req_kind = kind; req_process_tag = t; req_arrival_time = a;
      req_burst_time = b; req_priority_level = pr;
      do @(posedge clock); while (busy);
      sb.note_word(kind, t, a, b, pr);
      words_sent++;
      if (kind == KIND_RUN) runs_sent++;
      @(negedge clock);
      start = 0;
   endtask

   // Hold off until every expected word has come and the block has settled.
   task automatic drain();
      @(negedge clock);
      while (sb.pending.size() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      drain();
      csr_we = 1; csr_index = idx; csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
      sb.set_reg(idx, data);
   endtask

   task automatic load_job(logic [7:0] t, logic [15:0] a, logic [15:0] b, logic [7:0] pr);
      send_word(KIND_LOAD, t, a, b, pr);
   endtask

   task automatic run_table();
      send_word(KIND_RUN, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic clear_table();
      send_word(KIND_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // One random phase: fresh table, then runs under one to three policies.
   task automatic random_phase();
      int n, k, rounds, r;
      bit heavy, wide_arr;
      logic [2:0] p;
      logic [15:0] b, a;
      heavy = ($urandom_range(99) < 15);
      wide_arr = ($urandom_range(99) < 20);
      n = ($urandom_range(99) < 6) ? $urandom_range(32, 35) : $urandom_range(1, 8);
      clear_table();
      for (k = 0; k < n; k++) begin
         // keep bursts short unless a heavy phase uses per-job policies only
         b = heavy ? 16'($urandom) : 16'($urandom_range(0, 12));
         a = wide_arr ? 16'($urandom) : 16'($urandom_range(0, 30));
         load_job(8'($urandom), a, b, 8'($urandom));
         if ($urandom_range(99) < 3) begin
            send_word(2'd3, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
         end
      end
      rounds = $urandom_range(1, 3);
      for (r = 0; r < rounds; r++) begin
         p = 3'($urandom_range(0, 7));
         if (heavy || n > 8) while (p == POL_RR || p == POL_SRTF) p = 3'($urandom_range(0, 7));
         write_reg(CSR_POLICY, {13'($urandom), p});
         if (p == POL_RR) begin
            if (heavy) write_reg(CSR_QUANTUM, 16'($urandom));
            else write_reg(CSR_QUANTUM, 16'($urandom_range(0, 6)));
         end
         run_table();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 0;

      // Directed: reset settings, empty table, extremes, every policy.
      run_table();                               // empty table, no words
      load_job(8'd0, 16'd0, 16'd1, 8'd255);
      load_job(8'd255, 16'd65535, 16'd65535, 8'd0);
      load_job(8'h5a, 16'd0, 16'd0, 8'd7);       // zero burst finishes on dispatch
      load_job(8'ha5, 16'd3, 16'd9, 8'd7);
      load_job(8'h11, 16'd3, 16'd9, 8'd7);       // ties broken by arrival then order
      send_word(2'd3, 8'hff, 16'hffff, 16'hffff, 8'hff);  // unused kind, ignored
      run_table();                               // reset policy and quantum
      write_reg(CSR_POLICY, 16'(POL_SJF));  run_table();
      write_reg(CSR_POLICY, 16'(POL_PRI));  run_table();
      write_reg(CSR_POLICY, 16'(POL_HRRN)); run_table();
      clear_table();
      load_job(8'd1, 16'd0, 16'd5, 8'd3);
      load_job(8'd2, 16'd1, 16'd0, 8'd2);
      load_job(8'd3, 16'd40, 16'd3, 8'd1);       // idle gap before this one
      load_job(8'd4, 16'd2, 16'd2, 8'd0);
      write_reg(CSR_POLICY, 16'(POL_RR));   run_table();
      write_reg(CSR_QUANTUM, 16'd0);   run_table();   // zero quantum acts as one
      write_reg(CSR_QUANTUM, 16'hffff); run_table();
      write_reg(CSR_POLICY, 16'(POL_SRTF)); run_table();
      write_reg(2'd2, 16'h1234);
      write_reg(2'd3, 16'hffff);                 // beyond the register list
      write_reg(CSR_POLICY, 16'hfff8 | 16'd7); run_table();   // unused code runs FCFS
      write_reg(CSR_POLICY, 16'd6);    run_table();

      // Random phases; the middle stretch runs with no sender idling.
      while (words_sent < 380) begin
         calm = (words_sent > 150 && words_sent < 230);
         random_phase();
      end
      calm = 0;

      drain();
      repeat (50) @(negedge clock);
      $display("Covered %0d words, %0d schedule runs, %0d completions checked.",
               words_sent, runs_sent, sb.seen);
      $display("All six policies, unused codes, overflow and zero bursts exercised.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
